// ===== rtl/ppp_pkg.sv =====
`timescale 1ns / 1ps
package ppp_pkg;

  localparam int MaxPointsDef   = 16;
  localparam int MaxLeadSegsDef = 8;
  localparam int MaxLoopSegsDef = 8;

  localparam logic [2:0] CMD_SET_START = 3'd0;
  localparam logic [2:0] CMD_ADD_LEAD  = 3'd1;
  localparam logic [2:0] CMD_ADD_LOOP  = 3'd2;
  localparam logic [2:0] CMD_SET_LOOP  = 3'd3;
  localparam logic [2:0] CMD_QUERY     = 3'd4;
  localparam logic [2:0] CMD_CLEAR     = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [30:0]        seg_speed;
    logic               is_velocity;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        time_value;
  } ppp_item_t;

  typedef struct packed {
    logic [3:0]         out_point;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               last;
  } ppp_result_t;

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               vel;
    logic [30:0]        speed;
  } ppp_lead_t;

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic [30:0]        speed;
  } ppp_loop_t;

endpackage

// ===== rtl/piecewise_path_position_top.sv =====
`timescale 1ns / 1ps
// channel  | ports                         | transfer
// command  | start, busy, item_i           | start high and busy low at a rising edge
// result   | res_valid_o, res_o            | res_valid_o high for one cycle, always taken
// a load or clear leaves busy low; a query walks each point and its segments in turn
// each segment passed uses two squares on the shared 32x32 multiplier, a 32-step
// square root and a 64-step shared divider; a zero-speed segment skips all three
// the segment a point stops inside adds a multiply and a divide per axis, a velocity
// segment a multiply per axis only; a loop modulo adds one pass of the divider
// busy stays high for the whole query; reset clears counts, durations and the sequencer
module piecewise_path_position_top
  import ppp_pkg::*;
#(
  parameter int MAX_POINTS    = MaxPointsDef,
  parameter int MAX_LEAD_SEGS = MaxLeadSegsDef,
  parameter int MAX_LOOP_SEGS = MaxLoopSegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ppp_item_t   item_i,
  output logic        res_valid_o,
  output ppp_result_t res_o
);

  localparam int PIW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCW   = $clog2(MAX_POINTS + 1);
  localparam int MAXS  = (MAX_LEAD_SEGS > MAX_LOOP_SEGS) ? MAX_LEAD_SEGS : MAX_LOOP_SEGS;
  localparam int JW    = $clog2(MAXS + 1);
  localparam int LDEP  = MAX_POINTS * MAX_LEAD_SEGS;
  localparam int ODEP  = MAX_POINTS * MAX_LOOP_SEGS;
  localparam int LAW   = (LDEP > 1) ? $clog2(LDEP) : 1;
  localparam int OAW   = (ODEP > 1) ? $clog2(ODEP) : 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PINIT = 5'd1;
  localparam logic [4:0] S_SRD   = 5'd2;
  localparam logic [4:0] S_SWAIT = 5'd3;
  localparam logic [4:0] S_DIFF  = 5'd4;
  localparam logic [4:0] S_SQ1   = 5'd5;
  localparam logic [4:0] S_SQ2   = 5'd6;
  localparam logic [4:0] S_SQ3   = 5'd7;
  localparam logic [4:0] S_SQ4   = 5'd8;
  localparam logic [4:0] S_SQRT  = 5'd9;
  localparam logic [4:0] S_TDIV  = 5'd10;
  localparam logic [4:0] S_DIV   = 5'd11;
  localparam logic [4:0] S_DDONE = 5'd12;
  localparam logic [4:0] S_DEC   = 5'd13;
  localparam logic [4:0] S_IMUL1 = 5'd14;
  localparam logic [4:0] S_IMUL2 = 5'd15;
  localparam logic [4:0] S_IMUL3 = 5'd16;
  localparam logic [4:0] S_LINIT = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  localparam logic [1:0] RET_SEG    = 2'd0;
  localparam logic [1:0] RET_INTERP = 2'd1;
  localparam logic [1:0] RET_MOD    = 2'd2;

  ppp_lead_t lead_mem [LDEP];
  ppp_loop_t loop_mem [ODEP];
  ppp_lead_t lead_rd_q;
  ppp_loop_t loop_rd_q;

  logic signed [31:0] start_x_q [MAX_POINTS];
  logic signed [31:0] start_y_q [MAX_POINTS];
  logic [JW-1:0]      lead_cnt_q [MAX_POINTS];
  logic [JW-1:0]      loop_cnt_q [MAX_POINTS];
  logic [30:0]        loop_len_q [MAX_POINTS];
  logic [PCW-1:0]     pcount_q;

  logic [4:0]         state_q;
  logic [1:0]         ret_q;
  logic [PCW-1:0]     p_q;
  logic [JW-1:0]      j_q;
  logic               phase_q, ax_q, vel_q, half_q;
  logic [30:0]        t_q, rem_q, spd_q;
  logic signed [31:0] cx_q, cy_q, ex_q, ey_q, vx_q, vy_q, fx_q, fy_q;
  logic [31:0]        a_q, b_q, mul_a_q, mul_b_q;
  logic [63:0]        prod_q, acc_q, root_q, bit_q, st_q, dn_q, dd_q;
  logic [64:0]        dr_q;
  logic [5:0]         cnt_q;
  ppp_result_t        res_q;
  logic               res_valid_q;

  logic [PIW-1:0]     pi, wi;
  logic [JW-1:0]      seg_cnt;
  logic               seg_last, in_range, ld_go;
  logic signed [32:0] dx, dy, d_ax;
  logic [31:0]        mag_x, mag_y, mag_ax, mag_v;
  logic signed [31:0] v_ax, cur_ax;
  logic [64:0]        div_r2;
  logic               div_ge;
  logic [63:0]        sq_try, q_sel;
  logic               neg_sel;
  logic signed [65:0] sum_ax;
  logic signed [31:0] sat_ax;
  logic [LAW-1:0]     lead_wa, lead_ra;
  logic [OAW-1:0]     loop_wa, loop_ra;

  assign pi       = p_q[PIW-1:0];
  assign wi       = PIW'(item_i.point_index);
  assign in_range = int'(item_i.point_index) < MAX_POINTS;
  assign ld_go    = start && !busy && in_range;
  assign seg_cnt  = phase_q ? loop_cnt_q[pi] : lead_cnt_q[pi];
  assign seg_last = (j_q == seg_cnt - JW'(1));

  assign lead_wa = LAW'(int'(wi) * MAX_LEAD_SEGS + int'(lead_cnt_q[wi]));
  assign loop_wa = OAW'(int'(wi) * MAX_LOOP_SEGS + int'(loop_cnt_q[wi]));
  assign lead_ra = LAW'(int'(pi) * MAX_LEAD_SEGS + int'(j_q));
  assign loop_ra = OAW'(int'(pi) * MAX_LOOP_SEGS + int'(j_q));

  assign dx     = 33'(ex_q) - 33'(cx_q);
  assign dy     = 33'(ey_q) - 33'(cy_q);
  assign mag_x  = dx[32] ? 32'(-dx) : dx[31:0];
  assign mag_y  = dy[32] ? 32'(-dy) : dy[31:0];
  assign d_ax   = ax_q ? dy : dx;
  assign mag_ax = ax_q ? mag_y : mag_x;
  assign v_ax   = ax_q ? vy_q : vx_q;
  assign mag_v  = v_ax[31] ? 32'(-33'(v_ax)) : 32'(v_ax);
  assign cur_ax = ax_q ? cy_q : cx_q;

  assign div_r2 = {dr_q[63:0], dn_q[63]};
  assign div_ge = div_r2 >= {1'b0, dd_q};
  assign sq_try = root_q + bit_q;

  // position step along one axis, saturated
  assign q_sel   = vel_q ? {16'd0, prod_q[63:16]} : dn_q;
  assign neg_sel = vel_q ? v_ax[31] : d_ax[32];
  assign sum_ax  = neg_sel ? 66'(cur_ax) - $signed({2'b00, q_sel})
                           : 66'(cur_ax) + $signed({2'b00, q_sel});
  assign sat_ax  = (sum_ax > 66'sd2147483647) ? 32'sh7fffffff :
                   (sum_ax < -66'sd2147483648) ? 32'sh80000000 : sum_ax[31:0];

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a_q) * 64'(mul_b_q);
    if (ld_go && item_i.cmd == CMD_ADD_LEAD && int'(lead_cnt_q[wi]) < MAX_LEAD_SEGS) begin
      lead_mem[lead_wa] <= '{ex: item_i.coord_x, ey: item_i.coord_y, vx: item_i.vel_x,
                             vy: item_i.vel_y, vel: item_i.is_velocity,
                             speed: item_i.seg_speed};
    end
    if (ld_go && item_i.cmd == CMD_ADD_LOOP && int'(loop_cnt_q[wi]) < MAX_LOOP_SEGS) begin
      loop_mem[loop_wa] <= '{ex: item_i.coord_x, ey: item_i.coord_y,
                             speed: item_i.seg_speed};
    end
    if (state_q == S_SRD) begin
      lead_rd_q <= lead_mem[lead_ra];
      loop_rd_q <= loop_mem[loop_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pcount_q    <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        lead_cnt_q[i] <= '0;
        loop_cnt_q[i] <= '0;
        loop_len_q[i] <= '0;
      end
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            if (item_i.cmd == CMD_QUERY) begin
              t_q <= item_i.time_value;
              p_q <= '0;
              if (pcount_q != '0) state_q <= S_PINIT;
            end else if (item_i.cmd == CMD_CLEAR) begin
              pcount_q <= '0;
              for (int i = 0; i < MAX_POINTS; i++) begin
                lead_cnt_q[i] <= '0;
                loop_cnt_q[i] <= '0;
                loop_len_q[i] <= '0;
                start_x_q[i]  <= '0;
                start_y_q[i]  <= '0;
              end
            end else if (in_range) begin
              case (item_i.cmd)
                CMD_SET_START: begin
                  start_x_q[wi] <= item_i.coord_x;
                  start_y_q[wi] <= item_i.coord_y;
                  if (int'(pcount_q) < int'(item_i.point_index) + 1) begin
                    pcount_q <= PCW'(int'(item_i.point_index) + 1);
                  end
                end
                CMD_ADD_LEAD: begin
                  if (int'(lead_cnt_q[wi]) < MAX_LEAD_SEGS) lead_cnt_q[wi] <= lead_cnt_q[wi] + JW'(1);
                end
                CMD_ADD_LOOP: begin
                  if (int'(loop_cnt_q[wi]) < MAX_LOOP_SEGS) loop_cnt_q[wi] <= loop_cnt_q[wi] + JW'(1);
                end
                CMD_SET_LOOP: begin
                  loop_len_q[wi] <= item_i.time_value;
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_PINIT: begin
          cx_q    <= start_x_q[pi];
          cy_q    <= start_y_q[pi];
          fx_q    <= start_x_q[pi];
          fy_q    <= start_y_q[pi];
          rem_q   <= t_q;
          j_q     <= '0;
          phase_q <= 1'b0;
          state_q <= S_SRD;
        end
        S_SRD: begin
          if (j_q == seg_cnt) state_q <= phase_q ? S_OUT : S_LINIT;
          else state_q <= S_SWAIT;
        end
        S_SWAIT: begin
          if (phase_q) begin
            ex_q  <= loop_rd_q.ex;
            ey_q  <= loop_rd_q.ey;
            spd_q <= loop_rd_q.speed;
            vel_q <= 1'b0;
          end else begin
            ex_q  <= lead_rd_q.ex;
            ey_q  <= lead_rd_q.ey;
            vx_q  <= lead_rd_q.vx;
            vy_q  <= lead_rd_q.vy;
            spd_q <= lead_rd_q.speed;
            vel_q <= lead_rd_q.vel;
          end
          ax_q    <= 1'b0;
          state_q <= (!phase_q && lead_rd_q.vel) ? S_IMUL1 : S_DIFF;
        end
        S_DIFF: begin
          half_q <= mag_x[31] | mag_y[31];
          a_q    <= (mag_x[31] | mag_y[31]) ? {1'b0, mag_x[31:1]} : mag_x;
          b_q    <= (mag_x[31] | mag_y[31]) ? {1'b0, mag_y[31:1]} : mag_y;
          if (spd_q == '0) begin
            st_q    <= '0;
            state_q <= S_DEC;
          end else begin
            state_q <= S_SQ1;
          end
        end
        S_SQ1: begin
          mul_a_q <= a_q;
          mul_b_q <= a_q;
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          mul_a_q <= b_q;
          mul_b_q <= b_q;
          state_q <= S_SQ3;
        end
        S_SQ3: begin
          acc_q   <= prod_q;
          state_q <= S_SQ4;
        end
        S_SQ4: begin
          acc_q   <= acc_q + prod_q;
          root_q  <= '0;
          bit_q   <= 64'd1 << 62;
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (acc_q >= sq_try) begin
            acc_q  <= acc_q - sq_try;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) state_q <= S_TDIV;
        end
        S_TDIV: begin
          dn_q    <= (half_q ? root_q << 1 : root_q) << 16;
          dd_q    <= {33'd0, spd_q};
          dr_q    <= '0;
          cnt_q   <= '0;
          ret_q   <= RET_SEG;
          state_q <= S_DIV;
        end
        S_DIV: begin
          dr_q  <= div_ge ? div_r2 - {1'b0, dd_q} : div_r2;
          dn_q  <= {dn_q[62:0], div_ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_q <= S_DDONE;
        end
        S_DDONE: begin
          case (ret_q)
            RET_SEG: begin
              st_q    <= dn_q;
              state_q <= S_DEC;
            end
            RET_INTERP: begin
              if (ax_q) fy_q <= sat_ax;
              else fx_q <= sat_ax;
              ax_q    <= 1'b1;
              state_q <= ax_q ? S_OUT : S_IMUL1;
            end
            RET_MOD: begin
              rem_q   <= dr_q[30:0];
              j_q     <= '0;
              phase_q <= 1'b1;
              state_q <= S_SRD;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DEC: begin
          if ({33'd0, rem_q} <= st_q || (st_q == '0 && seg_last)) begin
            if (st_q == '0 || {33'd0, rem_q} >= st_q) begin
              fx_q    <= ex_q;
              fy_q    <= ey_q;
              state_q <= S_OUT;
            end else begin
              ax_q    <= 1'b0;
              state_q <= S_IMUL1;
            end
          end else begin
            rem_q <= rem_q - st_q[30:0];
            cx_q  <= ex_q;
            cy_q  <= ey_q;
            if (seg_last) begin
              fx_q <= ex_q;
              fy_q <= ey_q;
            end
            j_q     <= j_q + JW'(1);
            state_q <= S_SRD;
          end
        end
        S_IMUL1: begin
          mul_a_q <= vel_q ? mag_v : mag_ax;
          mul_b_q <= {1'b0, rem_q};
          state_q <= S_IMUL2;
        end
        S_IMUL2: begin
          state_q <= S_IMUL3;
        end
        S_IMUL3: begin
          if (vel_q) begin
            if (ax_q) fy_q <= sat_ax;
            else fx_q <= sat_ax;
            ax_q    <= 1'b1;
            state_q <= ax_q ? S_OUT : S_IMUL1;
          end else begin
            dn_q    <= prod_q;
            dd_q    <= st_q;
            dr_q    <= '0;
            cnt_q   <= '0;
            ret_q   <= RET_INTERP;
            state_q <= S_DIV;
          end
        end
        S_LINIT: begin
          if (loop_cnt_q[pi] != '0 && loop_len_q[pi] != '0) begin
            dn_q    <= {33'd0, t_q};
            dd_q    <= {33'd0, loop_len_q[pi]};
            dr_q    <= '0;
            cnt_q   <= '0;
            ret_q   <= RET_MOD;
            state_q <= S_DIV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          res_valid_q     <= 1'b1;
          res_q.out_point <= 4'(p_q);
          res_q.pos_x     <= fx_q;
          res_q.pos_y     <= fy_q;
          res_q.last      <= (p_q + PCW'(1) == pcount_q);
          p_q             <= p_q + PCW'(1);
          state_q         <= (p_q + PCW'(1) == pcount_q) ? S_IDLE : S_PINIT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
